@@ hdl/ecr_pkg.sv @@
package ecr_pkg;

    localparam int DATA_W    = 32;
    localparam int FRAC_W    = 16;
    localparam int OPERANDS  = 4;
    localparam int DIV_STEPS = DATA_W;
    localparam int FRONT_LEN = 3;
    localparam int STEP_LEN  = DIV_STEPS + 2;
    localparam int STEPS     = OPERANDS - 1;
    localparam int STAGES    = FRONT_LEN + STEPS * STEP_LEN;
    localparam int LAST      = STAGES - 1;

    localparam logic signed [65:0] WIDE_MAX = 66'sd2147483647;
    localparam logic signed [65:0] WIDE_MIN = -66'sd2147483648;
    localparam logic [31:0] VAL_MAX = 32'h7FFF_FFFF;
    localparam logic [31:0] VAL_MIN = 32'h8000_0000;

    typedef enum logic [1:0] {
        OP_SUM  = 2'd0,
        OP_PROD = 2'd1,
        OP_MAX  = 2'd2,
        OP_DIV  = 2'd3
    } t_op;

    typedef enum logic [2:0] {
        CFG_OPERATION = 3'd0,
        CFG_RELU      = 3'd1,
        CFG_COUNT     = 3'd2,
        CFG_WEIGHT_A  = 3'd3,
        CFG_WEIGHT_B  = 3'd4,
        CFG_WEIGHT_C  = 3'd5,
        CFG_WEIGHT_D  = 3'd6
    } t_cfg_idx;

    typedef enum logic [2:0] {
        SM_PASS,
        SM_PROD,
        SM_RUN,
        SM_OVF,
        SM_DZERO
    } t_smode;

    typedef struct packed {
        logic [3:0][31:0] opnd;
        logic [31:0]      acc;
        logic             sat;
        logic [3:0][63:0] wprod;
        logic [1:0][64:0] psum;
        logic [63:0]      prod;
        t_smode           smode;
        logic             qneg;
        logic [31:0]      dvs;
        logic [32:0]      rem;
        logic [31:0]      sh;
        logic [31:0]      quo;
    } t_stage;

    typedef struct packed {
        logic [31:0] val;
        logic        sat;
    } t_sval;

    function automatic t_sval f_clamp(input logic signed [65:0] v);
        t_sval r;
        r.sat = 1'b0;
        r.val = v[31:0];
        if (v > WIDE_MAX) begin
            r.val = VAL_MAX;
            r.sat = 1'b1;
        end else if (v < WIDE_MIN) begin
            r.val = VAL_MIN;
            r.sat = 1'b1;
        end
        return r;
    endfunction

endpackage

@@ hdl/eltwise_combine_relu.sv @@
// Elementwise combiner for signed Q16.16 data. Each input word carries four
// operands; the first input_count of them are combined as a weighted sum,
// a chained product, a maximum or a chained division of operand a by the
// others, then an optional ReLU zeroes negative results. One result word
// per input word, in order, with a flag in tuser when any step saturated.
// One word per cycle enters unless the output stalls; a stall freezes the
// whole pipeline. A three-stage multiply/add front end feeds three chained
// steps, each a product or a 32-step restoring divider (one quotient bit
// per stage). Configuration must be written while the pipeline is empty.
module eltwise_combine_relu (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_cfg_we,
    input  logic [2:0]   i_cfg_addr,
    input  logic [31:0]  i_cfg_wdata,
    input  logic         i_s_axis_tvalid,
    output logic         o_s_axis_tready,
    // operand_a, operand_b, operand_c, operand_d
    input  logic [127:0] i_s_axis_tdata,
    output logic         o_m_axis_tvalid,
    input  logic         i_m_axis_tready,
    // result_value
    output logic [31:0]  o_m_axis_tdata,
    // saturated
    output logic [0:0]   o_m_axis_tuser
);

    ecr_pkg::t_op      r_op;
    logic              r_relu;
    logic [2:0]        r_count;
    logic [3:0][31:0]  r_wgt;
    logic [2:0]        w_n;
    logic              w_adv;

    logic [ecr_pkg::LAST:0] r_vld;
    ecr_pkg::t_stage        r_stg [ecr_pkg::STAGES];
    ecr_pkg::t_stage        w_in;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_op    <= ecr_pkg::OP_SUM;
            r_relu  <= 1'b0;
            r_count <= 3'd2;
            r_wgt   <= {4{32'h0001_0000}};
        end else if (i_cfg_we) begin
            case (ecr_pkg::t_cfg_idx'(i_cfg_addr))
                ecr_pkg::CFG_OPERATION: r_op    <= ecr_pkg::t_op'(i_cfg_wdata[1:0]);
                ecr_pkg::CFG_RELU:      r_relu  <= i_cfg_wdata[0];
                ecr_pkg::CFG_COUNT:     r_count <= i_cfg_wdata[2:0];
                ecr_pkg::CFG_WEIGHT_A:  r_wgt[0] <= i_cfg_wdata;
                ecr_pkg::CFG_WEIGHT_B:  r_wgt[1] <= i_cfg_wdata;
                ecr_pkg::CFG_WEIGHT_C:  r_wgt[2] <= i_cfg_wdata;
                ecr_pkg::CFG_WEIGHT_D:  r_wgt[3] <= i_cfg_wdata;
                default: ;
            endcase
        end
    end

    always_comb begin
        if (r_count == 3'd0) begin
            w_n = 3'd1;
        end else if (r_count > 3'd4) begin
            w_n = 3'd4;
        end else begin
            w_n = r_count;
        end
    end

    assign w_adv           = !r_vld[ecr_pkg::LAST] || i_m_axis_tready;
    assign o_s_axis_tready = w_adv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (w_adv) begin
            r_vld <= {r_vld[ecr_pkg::LAST-1:0], i_s_axis_tvalid};
        end
    end

    always_comb begin
        w_in      = '0;
        w_in.opnd = i_s_axis_tdata;
    end

    for (genvar s = 0; s < ecr_pkg::STAGES; s++) begin : g_stg
        ecr_pkg::t_stage p;
        ecr_pkg::t_stage n_st;

        if (s == 0) begin : g_src_in
            assign p = w_in;
        end else begin : g_src_reg
            assign p = r_stg[s-1];
        end

        if (s == 0) begin : g_f0
            always_comb begin
                logic [31:0] m;
                n_st = p;
                m = p.opnd[0];
                for (int i = 1; i < 4; i++) begin
                    if (3'(i) < w_n && $signed(p.opnd[i]) > $signed(m)) begin
                        m = p.opnd[i];
                    end
                end
                for (int i = 0; i < 4; i++) begin
                    n_st.wprod[i] = (3'(i) < w_n)
                        ? 64'($signed(r_wgt[i])) * 64'($signed(p.opnd[i])) : 64'd0;
                end
                n_st.acc   = (r_op == ecr_pkg::OP_MAX) ? m : p.opnd[0];
                n_st.sat   = 1'b0;
                n_st.smode = ecr_pkg::SM_PASS;
            end
        end else if (s == 1) begin : g_f1
            always_comb begin
                n_st = p;
                n_st.psum[0] = 65'($signed({p.wprod[0][63], p.wprod[0]})
                                 + $signed({p.wprod[1][63], p.wprod[1]}));
                n_st.psum[1] = 65'($signed({p.wprod[2][63], p.wprod[2]})
                                 + $signed({p.wprod[3][63], p.wprod[3]}));
            end
        end else if (s == 2) begin : g_f2
            always_comb begin
                logic signed [65:0] tot;
                ecr_pkg::t_sval     cv;
                n_st = p;
                tot  = $signed({p.psum[0][64], p.psum[0]})
                     + $signed({p.psum[1][64], p.psum[1]});
                cv   = ecr_pkg::f_clamp(tot >>> ecr_pkg::FRAC_W);
                if (r_op == ecr_pkg::OP_SUM) begin
                    n_st.acc = cv.val;
                    n_st.sat = cv.sat;
                end
            end
        end else begin : g_step
            localparam int K = (s - ecr_pkg::FRONT_LEN) / ecr_pkg::STEP_LEN + 1;
            localparam int J = (s - ecr_pkg::FRONT_LEN) % ecr_pkg::STEP_LEN;

            if (J == 0) begin : g_prep
                always_comb begin
                    logic [31:0] x;
                    logic [31:0] amag;
                    logic [31:0] dmag;
                    n_st = p;
                    x    = p.opnd[K];
                    amag = p.acc[31] ? 32'(-p.acc) : p.acc;
                    dmag = x[31] ? 32'(-x) : x;
                    n_st.smode = ecr_pkg::SM_PASS;
                    n_st.prod  = 64'($signed(p.acc)) * 64'($signed(x));
                    n_st.qneg  = p.acc[31] ^ x[31];
                    n_st.dvs   = dmag;
                    n_st.rem   = {17'd0, amag[31:16]};
                    n_st.sh    = {amag[15:0], 16'd0};
                    n_st.quo   = '0;
                    if (3'(K) < w_n) begin
                        if (r_op == ecr_pkg::OP_PROD) begin
                            n_st.smode = ecr_pkg::SM_PROD;
                        end else if (r_op == ecr_pkg::OP_DIV) begin
                            if (x == 32'd0) begin
                                n_st.smode = ecr_pkg::SM_DZERO;
                            end else if ({16'd0, amag} >= {dmag, 16'd0}) begin
                                n_st.smode = ecr_pkg::SM_OVF;
                            end else begin
                                n_st.smode = ecr_pkg::SM_RUN;
                            end
                        end
                    end
                end
            end else if (J <= ecr_pkg::DIV_STEPS) begin : g_iter
                always_comb begin
                    logic [32:0] trial;
                    logic        ge;
                    n_st  = p;
                    trial = {p.rem[31:0], p.sh[31]};
                    ge    = trial >= {1'b0, p.dvs};
                    n_st.rem = ge ? trial - {1'b0, p.dvs} : trial;
                    n_st.sh  = {p.sh[30:0], 1'b0};
                    n_st.quo = {p.quo[30:0], ge};
                end
            end else begin : g_fin
                always_comb begin
                    logic signed [65:0] qv;
                    ecr_pkg::t_sval     cv;
                    n_st = p;
                    qv   = p.qneg ? -$signed({34'd0, p.quo}) : $signed({34'd0, p.quo});
                    cv   = '0;
                    unique case (p.smode)
                        ecr_pkg::SM_PROD: begin
                            cv = ecr_pkg::f_clamp(66'($signed(p.prod) >>> ecr_pkg::FRAC_W));
                        end
                        ecr_pkg::SM_RUN: begin
                            cv = ecr_pkg::f_clamp(qv);
                        end
                        ecr_pkg::SM_OVF: begin
                            cv.val = p.qneg ? ecr_pkg::VAL_MIN : ecr_pkg::VAL_MAX;
                            cv.sat = 1'b1;
                        end
                        ecr_pkg::SM_DZERO: begin
                            if ($signed(p.acc) > 0) begin
                                cv.val = ecr_pkg::VAL_MAX;
                                cv.sat = 1'b1;
                            end else if ($signed(p.acc) < 0) begin
                                cv.val = ecr_pkg::VAL_MIN;
                                cv.sat = 1'b1;
                            end
                        end
                        ecr_pkg::SM_PASS: begin
                            cv.val = p.acc;
                        end
                        default: begin
                            cv.val = p.acc;
                        end
                    endcase
                    n_st.acc = cv.val;
                    n_st.sat = p.sat | cv.sat;
                end
            end
        end

        always_ff @(posedge i_clk) begin
            if (w_adv) begin
                r_stg[s] <= n_st;
            end
        end
    end

    assign o_m_axis_tvalid = r_vld[ecr_pkg::LAST];
    assign o_m_axis_tdata  = (r_relu && r_stg[ecr_pkg::LAST].acc[31])
                             ? 32'd0 : r_stg[ecr_pkg::LAST].acc;
    assign o_m_axis_tuser  = r_stg[ecr_pkg::LAST].sat;

`ifndef SYNTHESIS
    a_stall_keeps: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_vld[ecr_pkg::LAST] && !i_m_axis_tready) |=> r_vld[ecr_pkg::LAST])
        else $error("output word dropped during stall");

    a_relu_nonneg: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && r_relu) |-> !o_m_axis_tdata[31])
        else $error("negative result with relu enabled");

    a_max_nosat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && r_op == ecr_pkg::OP_MAX) |-> !o_m_axis_tuser[0])
        else $error("maximum flagged as saturated");

    a_div_rem: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_vld[ecr_pkg::LAST] && r_stg[ecr_pkg::LAST].smode == ecr_pkg::SM_RUN)
        |-> (r_stg[ecr_pkg::LAST].rem < {1'b0, r_stg[ecr_pkg::LAST].dvs}))
        else $error("divider remainder out of range");
`endif

endmodule
